FILE: rtl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg: shared types and constants of the disk request scheduler
// status codes, policy codes, register indexes, fsm states, the cell command and default sizes
// ----------------------------------------------------------------------------
package drs_pkg;

	localparam int QueueDepthDef = 32;
	localparam int TrackBitsDef  = 16;
	localparam int CfgWidth      = 16;
	localparam int CfgIdxWidth   = 1;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_RANGE     = 3'd2,
		ST_SERVED    = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		POL_FCFS  = 2'd0,
		POL_SSTF  = 2'd1,
		POL_SCAN  = 2'd2,
		POL_CSCAN = 2'd3
	} policy_t;

	typedef enum logic [0:0] {
		REG_POLICY      = 1'b0,
		REG_TRACK_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_REMOVE,
		FSM_OUT
	} fsm_t;

	// command from the controller to the row of cells
	typedef struct packed {
		logic append;  // write the new track at the fill position
		logic rotate;  // shift every live cell one step toward the front
		logic remove;  // this rotation drops the cell at the front
	} cell_cmd_t;

endpackage

FILE: rtl/drs_cell.sv
// ----------------------------------------------------------------------------
// drs_cell: one queue slot of the request ring
// holds one track; shifts in its neighbor's track, or loads the load value
// ----------------------------------------------------------------------------
module drs_cell #(
	parameter int TRACK_BITS = drs_pkg::TrackBitsDef
) (
	input  logic                  clk,
	input  logic                  load,
	input  logic [TRACK_BITS-1:0] load_track,
	input  logic                  shift,
	input  logic [TRACK_BITS-1:0] next_track,
	output logic [TRACK_BITS-1:0] track
);

	logic [TRACK_BITS-1:0] track_q;

	always_ff @(posedge clk) begin
		if (load) begin
			track_q <= load_track;
		end else if (shift) begin
			track_q <= next_track;
		end
	end

	assign track = track_q;

endmodule

FILE: rtl/drs_row.sv
// ----------------------------------------------------------------------------
// drs_row: chain of request cells
// a rotation moves every live cell one place toward the front; the front item
// either wraps to the last live slot or drops out when it is removed
// ----------------------------------------------------------------------------
module drs_row #(
	parameter int QUEUE_DEPTH = drs_pkg::QueueDepthDef,
	parameter int TRACK_BITS  = drs_pkg::TrackBitsDef,
	localparam int CntW       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                  clk,
	input  drs_pkg::cell_cmd_t    cmd,
	input  logic [CntW-1:0]       count,
	input  logic [TRACK_BITS-1:0] new_track,
	output logic [TRACK_BITS-1:0] front
);

	logic [TRACK_BITS-1:0] trk [QUEUE_DEPTH];
	logic [TRACK_BITS-1:0] nxt [QUEUE_DEPTH];

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		logic ld;
		logic sh;
		logic [TRACK_BITS-1:0] ldv;
		// on append, slot count takes the new track
		// on rotate, slot count-1 takes the old front unless it is removed
		always_comb begin
			ld  = 1'b0;
			ldv = new_track;
			if (cmd.append && count == CntW'(g)) begin
				ld = 1'b1;
			end else if (cmd.rotate && !cmd.remove && count == CntW'(g + 1)) begin
				ld  = 1'b1;
				ldv = trk[0];
			end
			sh = cmd.rotate && (CntW'(g + 1) < count);
		end
		if (g + 1 < QUEUE_DEPTH) begin : g_n
			assign nxt[g] = trk[g + 1];
		end else begin : g_l
			assign nxt[g] = trk[g];
		end
		drs_cell #(.TRACK_BITS(TRACK_BITS)) u_cell (
			.clk       (clk),
			.load      (ld),
			.load_track(ldv),
			.shift     (sh),
			.next_track(nxt[g]),
			.track     (trk[g])
		);
	end

	assign front = trk[0];

endmodule

FILE: rtl/disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// disk_request_scheduler: track request queue with fcfs/sstf/scan/cscan
// enqueue: from accept the block passes to the output state, then raises result valid
// serve: one full rotation of the cell ring to pick the entry, and a second
// to drop the chosen entry keeping the order of the rest
// one item at a time; the next item can be taken in the cycle after the result is taken
// reset: queue empty, head 1, direction outward, policy 0, track count 65535
// ----------------------------------------------------------------------------
module disk_request_scheduler #(
	parameter int QUEUE_DEPTH = drs_pkg::QueueDepthDef,
	parameter int TRACK_BITS  = drs_pkg::TrackBitsDef,
	localparam int CntW       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [drs_pkg::CfgIdxWidth-1:0] cfg_index,
	input  logic [drs_pkg::CfgWidth-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [15:0]                   track,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    status,
	output logic [15:0]                   served_track,
	output logic [15:0]                   head_position,
	output logic                          sweep_dir,
	output logic [5:0]                    pending
);

	logic [1:0]            policy_q;
	logic [15:0]           tcount_q;
	logic [CntW-1:0]       count_q;
	logic [TRACK_BITS-1:0] head_q;
	logic                  dir_q;
	logic [TRACK_BITS-1:0] newtrk_q;
	logic [CntW-1:0]       pos_q;
	logic [CntW-1:0]       sel_q;
	logic                  has_eq_q, has_ab_q, has_be_q;
	logic [CntW-1:0]       eq_q, ab_q, be_q, best_q, low_q;
	logic [TRACK_BITS-1:0] abt_q, bet_q, lowt_q;
	logic [TRACK_BITS:0]   bestd_q;
	logic [2:0]            st_q;
	logic [15:0]           srv_q;
	logic                  ov_q;
	logic                  removed_q;
	logic [CntW-1:0]       row_count;
	drs_pkg::fsm_t         state_q, state_d;
	drs_pkg::cell_cmd_t    cmd;
	logic [TRACK_BITS-1:0] front;
	logic [TRACK_BITS:0]   d;
	logic                  accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != drs_pkg::FSM_IDLE);

	// once the chosen entry has dropped out the ring is one slot shorter
	assign row_count = count_q - CntW'(removed_q);

	drs_row #(.QUEUE_DEPTH(QUEUE_DEPTH), .TRACK_BITS(TRACK_BITS)) u_row (
		.clk      (clk),
		.cmd      (cmd),
		.count    (row_count),
		.new_track(newtrk_q),
		.front    (front)
	);

	assign d = (front > head_q) ? {1'b0, front - head_q} : {1'b0, head_q - front};

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			drs_pkg::FSM_IDLE: begin
				if (accept) begin
					state_d = drs_pkg::FSM_OUT;
					if (op && count_q != '0) begin
						state_d = drs_pkg::FSM_SCAN;
					end
				end
			end
			drs_pkg::FSM_SCAN: begin
				cmd.rotate = 1'b1;
				if (pos_q == count_q - CntW'(1)) begin
					state_d = drs_pkg::FSM_REMOVE;
				end
			end
			drs_pkg::FSM_REMOVE: begin
				cmd.rotate = 1'b1;
				cmd.remove = (pos_q == sel_q);
				if (pos_q == count_q - CntW'(1)) begin
					state_d = drs_pkg::FSM_OUT;
				end
			end
			drs_pkg::FSM_OUT: begin
				cmd.append = (st_q == drs_pkg::ST_ACCEPTED) && !ov_q;
				if (ov_q && !out_stall) begin
					state_d = drs_pkg::FSM_IDLE;
				end
			end
			default: state_d = drs_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= drs_pkg::FSM_IDLE;
			policy_q <= '0;
			tcount_q <= 16'hFFFF;
			count_q  <= '0;
			head_q   <= TRACK_BITS'(1);
			dir_q    <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					drs_pkg::REG_POLICY:      policy_q <= cfg_data[1:0];
					drs_pkg::REG_TRACK_COUNT: tcount_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.append) begin
				count_q <= count_q + CntW'(1);
			end
			if (state_q == drs_pkg::FSM_REMOVE && state_d == drs_pkg::FSM_OUT) begin
				count_q <= count_q - CntW'(1);
				// the chosen entry may be at the front in this last step
				head_q  <= (pos_q == sel_q) ? front : TRACK_BITS'(srv_q);
			end
			if (state_q == drs_pkg::FSM_SCAN && state_d == drs_pkg::FSM_REMOVE &&
			    policy_q == drs_pkg::POL_SCAN && !has_eq_q &&
			    !(front == head_q)) begin
				// direction flips when nothing lies ahead, decided in final step
				if (!dir_q && !(has_ab_q || front > head_q)) dir_q <= 1'b1;
				else if (dir_q && !(has_be_q || front < head_q)) dir_q <= 1'b0;
			end
			if (state_q == drs_pkg::FSM_OUT && !ov_q) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// scan bookkeeping and selection
	always_ff @(posedge clk) begin
		if (accept) begin
			newtrk_q  <= TRACK_BITS'(track);
			pos_q     <= '0;
			has_eq_q  <= 1'b0;
			has_ab_q  <= 1'b0;
			has_be_q  <= 1'b0;
			removed_q <= 1'b0;
			srv_q     <= '0;
			if (!op) begin
				if (count_q >= CntW'(QUEUE_DEPTH)) st_q <= drs_pkg::ST_FULL;
				else if (32'(TRACK_BITS'(track)) >= 32'(tcount_q)) st_q <= drs_pkg::ST_RANGE;
				else st_q <= drs_pkg::ST_ACCEPTED;
			end else if (count_q == '0) begin
				st_q <= drs_pkg::ST_EMPTY;
			end else begin
				st_q <= drs_pkg::ST_SERVED;
			end
		end
		if (state_q == drs_pkg::FSM_SCAN) begin
			pos_q <= pos_q + CntW'(1);
			if (!has_eq_q && front == head_q) begin
				has_eq_q <= 1'b1;
				eq_q     <= pos_q;
			end
			if (front > head_q && (!has_ab_q || front < abt_q)) begin
				has_ab_q <= 1'b1;
				ab_q     <= pos_q;
				abt_q    <= front;
			end
			if (front < head_q && (!has_be_q || front > bet_q)) begin
				has_be_q <= 1'b1;
				be_q     <= pos_q;
				bet_q    <= front;
			end
			if (pos_q == '0 || d < bestd_q) begin
				best_q  <= pos_q;
				bestd_q <= d;
			end
			if (pos_q == '0 || front < lowt_q) begin
				low_q  <= pos_q;
				lowt_q <= front;
			end
			if (state_d == drs_pkg::FSM_REMOVE) begin
				pos_q <= '0;
			end
		end
		if (state_q == drs_pkg::FSM_REMOVE) begin
			pos_q <= pos_q + CntW'(1);
			if (pos_q == sel_q) begin
				srv_q     <= 16'(front);
				removed_q <= 1'b1;
			end
		end
	end

	// choose the slot at the end of the scan, including the last element
	logic                  f_eq, f_ab, f_be, f_bst, f_low;
	logic [CntW-1:0]       pick;
	always_comb begin
		f_eq  = !has_eq_q && front == head_q;
		f_ab  = front > head_q && (!has_ab_q || front < abt_q);
		f_be  = front < head_q && (!has_be_q || front > bet_q);
		f_bst = pos_q == '0 || d < bestd_q;
		f_low = pos_q == '0 || front < lowt_q;
		if (has_eq_q) pick = eq_q;
		else if (f_eq) pick = pos_q;
		else begin
			case (drs_pkg::policy_t'(policy_q))
				drs_pkg::POL_FCFS: pick = '0;
				drs_pkg::POL_SSTF: pick = f_bst ? pos_q : best_q;
				drs_pkg::POL_SCAN: begin
					if (!dir_q) begin
						if (f_ab) pick = pos_q;
						else if (has_ab_q) pick = ab_q;
						else pick = f_be ? pos_q : be_q;
					end else begin
						if (f_be) pick = pos_q;
						else if (has_be_q) pick = be_q;
						else pick = f_ab ? pos_q : ab_q;
					end
				end
				default: begin
					if (f_ab) pick = pos_q;
					else if (has_ab_q) pick = ab_q;
					else pick = f_low ? pos_q : low_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == drs_pkg::FSM_SCAN && state_d == drs_pkg::FSM_REMOVE) begin
			sel_q <= pick;
		end
	end

	assign out_valid     = ov_q;
	assign status        = st_q;
	assign served_track  = srv_q;
	assign head_position = 16'(head_q);
	assign sweep_dir     = dir_q;
	assign pending       = 6'(count_q);

endmodule

FILE: rtl/drs_checker.sv
// ----------------------------------------------------------------------------
// drs_checker: port-level checks of the disk request scheduler
// watches handshakes and result fields over time
// ----------------------------------------------------------------------------
module drs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [15:0] served_track,
	input logic [15:0] head_position,
	input logic [5:0]  pending
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result dropped while stalled");

	a_srv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == drs_pkg::ST_SERVED |-> served_track == head_position)
		else $error("served track differs from head");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != drs_pkg::ST_SERVED |-> served_track == '0)
		else $error("served track not zero");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result waits");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending <= 6'd32)
		else $error("pending over capacity");

endmodule

bind disk_request_scheduler drs_checker u_drs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.served_track (served_track),
	.head_position(head_position),
	.pending      (pending)
);

FILE: bench/disk_request_scheduler_tb.sv
// ----------------------------------------------------------------------------
// disk_request_scheduler_tb: self-checking bench for the disk request scheduler
// drives enqueue and serve items in random bursts under every policy and a
// range of track counts, predicts each result in a local copy of the queue
// and compares it field by field against the block's output
// ----------------------------------------------------------------------------
module disk_request_scheduler_tb;

	localparam int Depth = 32;
	localparam longint CycleLimit = 3000000;

	typedef struct {
		logic        op;
		logic [15:0] track;
	} sched_item_t;

	typedef struct {
		drs_pkg::status_t status;
		logic [15:0]      served_track;
		logic [15:0]      head_position;
		logic             sweep_dir;
		logic [5:0]       pending;
	} sched_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [drs_pkg::CfgIdxWidth-1:0] cfg_index = '0;
	logic [drs_pkg::CfgWidth-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b0;
	logic [15:0] track = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [15:0] served_track;
	logic [15:0] head_position;
	logic sweep_dir;
	logic [5:0] pending;

	disk_request_scheduler dut (.*);

	// predictor state
	drs_pkg::policy_t pol_m = drs_pkg::POL_FCFS;
	logic [15:0] tcount_m = 16'hFFFF;
	logic [15:0] queue_m[$];
	logic [15:0] head_m = 16'd1;
	logic        dir_m = 1'b0;

	sched_item_t   pending_items[$];
	sched_result_t expected_results[$];
	bit   failed = 1'b0;
	bit   stim_done = 1'b0;
	bit   hold_request = 1'b0;
	longint cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int seek(logic [15:0] t);
		return (t > head_m) ? int'(t - head_m) : int'(head_m - t);
	endfunction

	function automatic int choose_slot();
		int best, above, below;
		bit has_above, has_below;
		logic [15:0] t;
		best = 0; above = 0; below = 0; has_above = 0; has_below = 0;
		foreach (queue_m[i])
			if (queue_m[i] == head_m) return i;
		case (pol_m)
			drs_pkg::POL_FCFS: return 0;
			drs_pkg::POL_SSTF: begin
				for (int i = 1; i < queue_m.size(); i++)
					if (seek(queue_m[i]) < seek(queue_m[best])) best = i;
				return best;
			end
			default: begin
				foreach (queue_m[i]) begin
					t = queue_m[i];
					if (t > head_m && (!has_above || t < queue_m[above])) begin
						above = i; has_above = 1;
					end
					if (t < head_m && (!has_below || t > queue_m[below])) begin
						below = i; has_below = 1;
					end
					if (t < queue_m[best]) best = i;
				end
				if (pol_m == drs_pkg::POL_CSCAN) return has_above ? above : best;
				if (dir_m == 1'b0) begin
					if (has_above) return above;
					dir_m = 1'b1;
					return below;
				end
				if (has_below) return below;
				dir_m = 1'b0;
				return above;
			end
		endcase
	endfunction

	function automatic sched_result_t predict_schedule(sched_item_t it);
		sched_result_t r;
		int slot;
		r.served_track = '0;
		if (it.op == 1'b0) begin
			if (queue_m.size() >= Depth) r.status = drs_pkg::ST_FULL;
			else if (it.track >= tcount_m) r.status = drs_pkg::ST_RANGE;
			else begin
				queue_m.push_back(it.track);
				r.status = drs_pkg::ST_ACCEPTED;
			end
		end else if (queue_m.size() == 0) begin
			r.status = drs_pkg::ST_EMPTY;
		end else begin
			slot = choose_slot();
			r.served_track = queue_m[slot];
			queue_m.delete(slot);
			head_m = r.served_track;
			r.status = drs_pkg::ST_SERVED;
		end
		r.head_position = head_m;
		r.sweep_dir = dir_m;
		r.pending = 6'(queue_m.size());
		return r;
	endfunction

	// sender: bursts and gaps
	int gap_left = 0;
	int burst_left = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_results.push_back(predict_schedule(pending_items.pop_front()));
		end
		if (in_valid && in_stall) begin
			// hold the offered item
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else if (pending_items.size() > 0) begin
			in_valid <= 1'b1;
			op <= pending_items[0].op;
			track <= pending_items[0].track;
			if (burst_left == 0) begin
				burst_left <= $urandom_range(1, 12);
				if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 40);
			end else burst_left <= burst_left - 1;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: stall pattern, plus one long hold when asked
	int hold_left = 0;
	int stall_mode = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		if (hold_request && !hold_done && hold_left == 0) begin
			hold_left <= 3000;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1);
		end else begin
			if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	// result checker
	sched_result_t exp_r;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				failed = 1'b1;
			end else begin
				exp_r = expected_results.pop_front();
				if (status !== exp_r.status) begin
					$error("status expected %0d actual %0d", exp_r.status, status);
					failed = 1'b1;
				end
				if (served_track !== exp_r.served_track) begin
					$error("served_track expected %0d actual %0d",
						exp_r.served_track, served_track);
					failed = 1'b1;
				end
				if (head_position !== exp_r.head_position) begin
					$error("head_position expected %0d actual %0d",
						exp_r.head_position, head_position);
					failed = 1'b1;
				end
				if (sweep_dir !== exp_r.sweep_dir) begin
					$error("sweep_dir expected %0d actual %0d", exp_r.sweep_dir, sweep_dir);
					failed = 1'b1;
				end
				if (pending !== exp_r.pending) begin
					$error("pending expected %0d actual %0d", exp_r.pending, pending);
					failed = 1'b1;
				end
			end
		end
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic add_item(logic o, logic [15:0] t);
		sched_item_t it;
		it.op = o;
		it.track = t;
		pending_items.push_back(it);
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (2 * Depth + 10) @(posedge clk);
	endtask

	task automatic write_reg(drs_pkg::reg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == drs_pkg::REG_POLICY) pol_m = drs_pkg::policy_t'(val[1:0]);
		else tcount_m = val;
	endtask

	// random track: mostly within 0..span, sometimes anywhere or at the extremes
	function automatic logic [15:0] rand_track(int span);
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 1));
			default: return 16'($urandom_range(0, span));
		endcase
	endfunction

	initial begin
		int span, n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty serve, extremes, range edge, ties, head hit
		add_item(1'b1, 16'hFFFF);
		add_item(1'b0, 16'hFFFF);
		add_item(1'b0, 16'hFFFE);
		add_item(1'b0, 16'd0);
		add_item(1'b0, 16'd1);
		add_item(1'b0, 16'd0);
		add_item(1'b0, 16'h5555);
		add_item(1'b0, 16'hAAAA);
		for (int i = 0; i < 6; i++) add_item(1'b1, 16'd0);
		add_item(1'b1, 16'd0);
		drain();
		write_reg(drs_pkg::REG_TRACK_COUNT, 16'd0);
		add_item(1'b0, 16'd0);
		add_item(1'b1, 16'd0);
		drain();
		write_reg(drs_pkg::REG_TRACK_COUNT, 16'd1);
		add_item(1'b0, 16'd0);
		add_item(1'b0, 16'd1);
		// fill to full and past it
		for (int i = 0; i < 33; i++) add_item(1'b0, 16'd0);
		drain();

		for (int phase = 0; phase < 16; phase++) begin
			write_reg(drs_pkg::REG_POLICY, 16'(phase % 4));
			case (phase / 4)
				0: write_reg(drs_pkg::REG_TRACK_COUNT, 16'hFFFF);
				1: write_reg(drs_pkg::REG_TRACK_COUNT, 16'd50);
				2: write_reg(drs_pkg::REG_TRACK_COUNT, 16'd2);
				default: write_reg(drs_pkg::REG_TRACK_COUNT, 16'($urandom_range(100, 4000)));
			endcase
			span = (phase / 4 == 0) ? 200 : int'(tcount_m) + 2;
			// mixed enqueue and serve items on top of whatever is still queued
			n = 100;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 99) < 55) add_item(1'b0, rand_track(span));
				else add_item(1'b1, 16'($urandom));
			end
			if (phase == 5) hold_request = 1'b1;
			drain();
		end
		stim_done = 1'b1;
		if (failed) $display("SCOREBOARD MISMATCH");
		else $display("SCOREBOARD CLEAN");
		$finish;
	end

endmodule
